[src/wvmc_pkg.sv]
// package for the water valve mode controller: widths, codes and helpers
package wvmc_pkg;

    localparam int TIMER_BITS = 13;

    localparam int THR_W   = 12;
    localparam int CFG_T_W = 13;
    localparam int CFG_W   = 13;
    localparam int CIDX_W  = 3;

    localparam int OP_W    = 3;
    localparam int POT_W   = 10;
    localparam int LEVEL_W = 13;
    localparam int MODE_W  = 2;
    localparam int RANG_W  = 9;
    localparam int SCODE_W = 2;
    localparam int ANG_W   = 7;
    localparam int SERVO_W = 15;
    localparam int STAT_W  = 3;
    localparam int FRAC_W  = 8;

    localparam int CMP_W      = (TIMER_BITS > CFG_T_W) ? TIMER_BITS : CFG_T_W;
    localparam int RPROD_W    = TIMER_BITS + ANG_W;
    localparam int NUM_W      = RPROD_W + FRAC_W;
    localparam int DEN_W      = CFG_T_W;
    localparam int CNT_W      = $clog2(NUM_W + 1);
    localparam int POT_PROD_W = POT_W + ANG_W;

    localparam logic [CIDX_W-1:0] CFG_LOW_THR  = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_HIGH_THR = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_DWELL    = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_TIMEOUT  = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_RAMP     = 3'd4;

    localparam logic [THR_W-1:0]   RST_LOW_THR  = 12'd200;
    localparam logic [THR_W-1:0]   RST_HIGH_THR = 12'd300;
    localparam logic [CFG_T_W-1:0] RST_DWELL    = 13'd3000;
    localparam logic [CFG_T_W-1:0] RST_TIMEOUT  = 13'd5000;
    localparam logic [CFG_T_W-1:0] RST_RAMP     = 13'd3000;

    localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
    localparam logic [OP_W-1:0] OP_LEVEL  = 3'd1;
    localparam logic [OP_W-1:0] OP_MODE   = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOTE = 3'd3;
    localparam logic [OP_W-1:0] OP_SOURCE = 3'd4;

    localparam logic [MODE_W-1:0] MODE_AUTO   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MANUAL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UNCONN = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NA     = 2'd3;

    localparam logic [SCODE_W-1:0] SCODE_POT    = 2'd0;
    localparam logic [SCODE_W-1:0] SCODE_REMOTE = 2'd1;
    localparam logic SRC_POT    = 1'b0;
    localparam logic SRC_REMOTE = 1'b1;

    localparam logic [STAT_W-1:0] ST_NONE   = 3'd0;
    localparam logic [STAT_W-1:0] ST_LEVEL  = 3'd1;
    localparam logic [STAT_W-1:0] ST_ACCEPT = 3'd2;
    localparam logic [STAT_W-1:0] ST_REFUSE = 3'd3;
    localparam logic [STAT_W-1:0] ST_SOURCE = 3'd4;

    localparam logic [ANG_W-1:0] ANG_ZERO = 7'd0;
    localparam logic [ANG_W-1:0] ANG_HALF = 7'd45;
    localparam logic [ANG_W-1:0] ANG_FULL = 7'd90;

    localparam logic [POT_PROD_W-1:0] POT_GAIN = 17'd90;
    localparam logic [DEN_W-1:0]      POT_FULL = 13'd1023;

    function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

endpackage

[src/water_valve_mode_controller.sv]
// water valve mode controller: mode sequencer, servo ramp and serial divider
//
// Items are taken one at a time; the input stalls until the result of the
// current item has moved into the output register, and a new item can be
// taken while that result still waits downstream. Level reports, mode,
// remote and source commands go from idle straight to the finish state. A
// tick that interpolates a ramp position passes the ramp, check, multiply,
// divide and write states; one restoring divider produces one quotient bit per
// cycle over the TIMER_BITS + 15 bits of the scaled ramp product. The pot
// reading is scaled to degrees by a reciprocal add and shift in the accepting
// cycle. A tick that takes a ramp step without interpolating passes the ramp
// and check states, a tick without a ramp step goes straight to finish. The
// finish state holds while the previous result waits in the output register.
// Configuration writes are taken at any time and must come while idle.
module water_valve_mode_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [wvmc_pkg::OP_W-1:0]           i_operation,
    input  logic                                i_button_level,
    input  logic [wvmc_pkg::POT_W-1:0]          i_pot_sample,
    input  logic signed [wvmc_pkg::LEVEL_W-1:0] i_level_mm,
    input  logic [wvmc_pkg::MODE_W-1:0]         i_mode_code,
    input  logic signed [wvmc_pkg::RANG_W-1:0]  i_remote_angle,
    input  logic [wvmc_pkg::SCODE_W-1:0]        i_source_code,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [wvmc_pkg::SERVO_W-1:0]        o_servo_angle_q8,
    output logic                                o_servo_write,
    output logic [wvmc_pkg::MODE_W-1:0]         o_mode_now,
    output logic                                o_mode_changed,
    output logic                                o_source_now,
    output logic [wvmc_pkg::STAT_W-1:0]         o_status,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [wvmc_pkg::CIDX_W-1:0]         i_cfg_index,
    input  logic [wvmc_pkg::CFG_W-1:0]          i_cfg_data
);
    import wvmc_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RAMP = 4'd3;
    localparam logic [3:0] S_RCHK = 4'd4;
    localparam logic [3:0] S_RMUL = 4'd5;
    localparam logic [3:0] S_RDIV = 4'd6;
    localparam logic [3:0] S_RWR  = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    logic [3:0] r_state, n_state;

    logic [THR_W-1:0]   r_low_thr, r_high_thr;
    logic [CFG_T_W-1:0] r_dwell, r_timeout, r_ramp_ms;

    logic [MODE_W-1:0]         r_mode, n_mode;
    logic                      r_source, n_source;
    logic signed [LEVEL_W-1:0] r_level, n_level;
    logic [ANG_W-1:0]          r_remote_tgt, n_remote_tgt;
    logic [TIMER_BITS-1:0]     r_since_report, n_since_report;
    logic [TIMER_BITS-1:0]     r_since_low, n_since_low;
    logic [TIMER_BITS-1:0]     r_ramp_elapsed, n_ramp_elapsed;
    logic [ANG_W-1:0]          r_ramp_start, n_ramp_start;
    logic [ANG_W-1:0]          r_ramp_target, n_ramp_target;
    logic [SERVO_W-1:0]        r_pos, n_pos;
    logic                      r_ramp_active, n_ramp_active;
    logic                      r_button_prev, n_button_prev;

    logic [ANG_W-1:0]  r_target, n_target;
    logic [MODE_W-1:0] r_mode_before, n_mode_before;
    logic              r_wrote, n_wrote;
    logic              r_zero, n_zero;
    logic [STAT_W-1:0] r_status, n_status;

    logic [NUM_W-1:0] r_div_num, n_div_num;
    logic [DEN_W-1:0] r_div_rem, n_div_rem;
    logic [DEN_W-1:0] r_div_den, n_div_den;
    logic [CNT_W-1:0] r_div_cnt, n_div_cnt;

    logic               r_out_valid, n_out_valid;
    logic               out_load;
    logic [SERVO_W-1:0] r_out_servo;
    logic               r_out_wrote;
    logic [MODE_W-1:0]  r_out_mode;
    logic               r_out_changed;
    logic               r_out_source;
    logic [STAT_W-1:0]  r_out_status;

    logic [TIMER_BITS-1:0] sr_inc, sl_inc, re_inc;
    logic [MODE_W-1:0]     mode_tk;
    logic [ANG_W-1:0]      clamp_ang;
    logic [POT_PROD_W-1:0] pot_prod;
    logic [POT_PROD_W-1:0] pot_sum;
    logic [ANG_W-1:0]      pot_tgt;
    logic                  ramp_up;
    logic [ANG_W-1:0]      ramp_mag;
    logic [RPROD_W-1:0]    ramp_prod;
    logic [DEN_W:0]        div_trial, div_diff;
    logic                  div_ge;
    logic [SERVO_W-1:0]    ramp_base, ramp_q;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);

    assign sr_inc = sat_inc(r_since_report);
    assign sl_inc = sat_inc(r_since_low);
    assign re_inc = sat_inc(r_ramp_elapsed);

    assign mode_tk = (r_mode != MODE_NA && CMP_W'(sr_inc) > CMP_W'(r_timeout)) ? MODE_NA
                                                                             : r_mode;

    always_comb begin
        if (i_remote_angle[RANG_W-1]) begin
            clamp_ang = ANG_ZERO;
        end else if (i_remote_angle[RANG_W-2:0] > {1'b0, ANG_FULL}) begin
            clamp_ang = ANG_FULL;
        end else begin
            clamp_ang = i_remote_angle[ANG_W-1:0];
        end
    end

    assign pot_prod  = POT_PROD_W'(i_pot_sample) * POT_GAIN;
    // divide by 1023 as (x + (x >> 10) + 1) >> 10, exact for quotients below 1024
    assign pot_sum   = pot_prod + (pot_prod >> POT_W) + 1'b1;
    assign pot_tgt   = pot_sum[POT_W +: ANG_W];
    assign ramp_up   = (r_ramp_target >= r_ramp_start);
    assign ramp_mag  = ramp_up ? r_ramp_target - r_ramp_start : r_ramp_start - r_ramp_target;
    assign ramp_prod = RPROD_W'(r_ramp_elapsed) * RPROD_W'(ramp_mag);

    // one restoring step per cycle
    assign div_trial = {r_div_rem, r_div_num[NUM_W-1]};
    assign div_ge    = (div_trial >= {1'b0, r_div_den});
    assign div_diff  = div_trial - {1'b0, r_div_den};

    assign ramp_base = {r_ramp_start, {FRAC_W{1'b0}}};
    assign ramp_q    = r_div_num[SERVO_W-1:0];

    assign out_load = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state        = r_state;
        n_mode         = r_mode;
        n_source       = r_source;
        n_level        = r_level;
        n_remote_tgt   = r_remote_tgt;
        n_since_report = r_since_report;
        n_since_low    = r_since_low;
        n_ramp_elapsed = r_ramp_elapsed;
        n_ramp_start   = r_ramp_start;
        n_ramp_target  = r_ramp_target;
        n_pos          = r_pos;
        n_ramp_active  = r_ramp_active;
        n_button_prev  = r_button_prev;
        n_target       = r_target;
        n_mode_before  = r_mode_before;
        n_wrote        = r_wrote;
        n_zero         = r_zero;
        n_status       = r_status;
        n_div_num      = r_div_num;
        n_div_rem      = r_div_rem;
        n_div_den      = r_div_den;
        n_div_cnt      = r_div_cnt;
        n_out_valid    = r_out_valid && i_out_stall;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode_before = r_mode;
                    n_wrote       = 1'b0;
                    n_zero        = 1'b0;
                    n_status      = ST_NONE;
                    n_state       = S_FIN;
                    case (i_operation)
                        OP_TICK: begin
                            n_since_report = sr_inc;
                            n_since_low    = sl_inc;
                            if (r_ramp_active) begin
                                n_ramp_elapsed = re_inc;
                            end
                            n_mode = mode_tk;
                            if (!r_level[LEVEL_W-1]) begin
                                case (mode_tk)
                                    MODE_AUTO: begin
                                        if (r_level[THR_W-1:0] < r_low_thr) begin
                                            n_target    = ANG_ZERO;
                                            n_since_low = '0;
                                        end else if (r_level[THR_W-1:0] < r_high_thr) begin
                                            n_target = (CMP_W'(sl_inc) > CMP_W'(r_dwell))
                                                       ? ANG_HALF : ANG_ZERO;
                                        end else begin
                                            n_target = ANG_FULL;
                                        end
                                        n_button_prev = i_button_level;
                                        if (i_button_level && !r_button_prev) begin
                                            n_source = SRC_POT;
                                            n_mode   = MODE_MANUAL;
                                        end
                                        n_state = S_RAMP;
                                    end
                                    MODE_MANUAL: begin
                                        if (r_source == SRC_POT) begin
                                            n_button_prev = i_button_level;
                                            if (i_button_level && !r_button_prev) begin
                                                n_source = SRC_POT;
                                                n_mode   = MODE_AUTO;
                                            end
                                            n_target = pot_tgt;
                                            n_state  = S_RAMP;
                                        end else begin
                                            n_target = r_remote_tgt;
                                            n_state  = S_RAMP;
                                        end
                                    end
                                    MODE_UNCONN: begin
                                        n_wrote = 1'b1;
                                        n_zero  = 1'b1;
                                    end
                                    default: begin
                                    end
                                endcase
                            end
                        end
                        OP_LEVEL: begin
                            n_level        = i_level_mm;
                            n_since_report = '0;
                            if (r_mode == MODE_UNCONN || r_mode == MODE_NA) begin
                                n_mode = MODE_AUTO;
                            end
                            n_status = ST_LEVEL;
                        end
                        OP_MODE: begin
                            n_mode = i_mode_code;
                        end
                        OP_REMOTE: begin
                            if (r_mode == MODE_MANUAL && r_source == SRC_REMOTE) begin
                                n_remote_tgt = clamp_ang;
                                n_status     = ST_ACCEPT;
                            end else begin
                                n_status = ST_REFUSE;
                            end
                        end
                        OP_SOURCE: begin
                            if (i_source_code == SCODE_POT) begin
                                n_source = SRC_POT;
                                n_status = ST_SOURCE;
                            end else if (i_source_code == SCODE_REMOTE) begin
                                n_source = SRC_REMOTE;
                                n_status = ST_SOURCE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RDIV: begin
                n_div_rem = div_ge ? div_diff[DEN_W-1:0] : div_trial[DEN_W-1:0];
                n_div_num = {r_div_num[NUM_W-2:0], div_ge};
                n_div_cnt = r_div_cnt - 1'b1;
                if (r_div_cnt == CNT_W'(1)) begin
                    n_state = S_RWR;
                end
            end
            S_RAMP: begin
                if (r_target != r_ramp_target) begin
                    n_ramp_start   = r_pos[SERVO_W-1:FRAC_W];
                    n_ramp_target  = r_target;
                    n_ramp_elapsed = '0;
                    n_ramp_active  = 1'b1;
                end
                n_state = S_RCHK;
            end
            S_RCHK: begin
                if (!r_ramp_active) begin
                    n_state = S_FIN;
                end else if (CMP_W'(r_ramp_elapsed) >= CMP_W'(r_ramp_ms)) begin
                    n_pos         = {r_ramp_target, {FRAC_W{1'b0}}};
                    n_ramp_active = 1'b0;
                    n_wrote       = 1'b1;
                    n_state       = S_FIN;
                end else begin
                    n_state = S_RMUL;
                end
            end
            S_RMUL: begin
                n_div_num = {ramp_prod, {FRAC_W{1'b0}}};
                n_div_den = r_ramp_ms;
                n_div_rem = '0;
                n_div_cnt = CNT_W'(NUM_W);
                n_state   = S_RDIV;
            end
            S_RWR: begin
                n_pos   = ramp_up ? ramp_base + ramp_q : ramp_base - ramp_q;
                n_wrote = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_mode         <= MODE_AUTO;
            r_source       <= SRC_POT;
            r_level        <= '1;
            r_remote_tgt   <= ANG_ZERO;
            r_since_report <= '0;
            r_since_low    <= '0;
            r_ramp_elapsed <= '0;
            r_ramp_start   <= ANG_ZERO;
            r_ramp_target  <= ANG_ZERO;
            r_pos          <= '0;
            r_ramp_active  <= 1'b0;
            r_button_prev  <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_mode         <= n_mode;
            r_source       <= n_source;
            r_level        <= n_level;
            r_remote_tgt   <= n_remote_tgt;
            r_since_report <= n_since_report;
            r_since_low    <= n_since_low;
            r_ramp_elapsed <= n_ramp_elapsed;
            r_ramp_start   <= n_ramp_start;
            r_ramp_target  <= n_ramp_target;
            r_pos          <= n_pos;
            r_ramp_active  <= n_ramp_active;
            r_button_prev  <= n_button_prev;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_thr  <= RST_LOW_THR;
            r_high_thr <= RST_HIGH_THR;
            r_dwell    <= RST_DWELL;
            r_timeout  <= RST_TIMEOUT;
            r_ramp_ms  <= RST_RAMP;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_LOW_THR:  r_low_thr  <= i_cfg_data[THR_W-1:0];
                CFG_HIGH_THR: r_high_thr <= i_cfg_data[THR_W-1:0];
                CFG_DWELL:    r_dwell    <= i_cfg_data[CFG_T_W-1:0];
                CFG_TIMEOUT:  r_timeout  <= i_cfg_data[CFG_T_W-1:0];
                CFG_RAMP:     r_ramp_ms  <= i_cfg_data[CFG_T_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_target      <= n_target;
        r_mode_before <= n_mode_before;
        r_wrote       <= n_wrote;
        r_zero        <= n_zero;
        r_status      <= n_status;
        r_div_num     <= n_div_num;
        r_div_rem     <= n_div_rem;
        r_div_den     <= n_div_den;
        r_div_cnt     <= n_div_cnt;
        if (out_load) begin
            r_out_servo   <= r_zero ? '0 : r_pos;
            r_out_wrote   <= r_wrote;
            r_out_mode    <= r_mode;
            r_out_changed <= (r_mode != r_mode_before);
            r_out_source  <= r_source;
            r_out_status  <= r_status;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_servo_angle_q8 = r_out_servo;
    assign o_servo_write    = r_out_wrote;
    assign o_mode_now       = r_out_mode;
    assign o_mode_changed   = r_out_changed;
    assign o_source_now     = r_out_source;
    assign o_status         = r_out_status;

endmodule
